>>> hw/rtl/sfst_pkg.sv
package sfst_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 128;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int FIB_W       = CNT_W + 1;
   localparam int SW          = CNT_W + 2;

   // Field widths.
   localparam int ID_W        = 32;
   localparam int TAG_W       = 16;
   localparam int REC_W       = ID_W + TAG_W;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_NOW_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_SEARCH = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_MISS  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_FIB_INIT,
      ST_FIB_RD,
      ST_FIB_CMP,
      ST_LAST_CMP,
      ST_HIT_RD,
      ST_HIT_W0,
      ST_HIT_WH,
      ST_DONE
   } state_type;

   // Memory port controls from the sequencer.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [REC_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_ctl_type;

   // Handshake status from the sequencer.
   typedef struct packed {
      logic idle;
      logic done;
   } seq_stat_type;

   typedef struct packed {
      status_type              status;
      logic [ID_W-1:0]         found_id;
      logic [TAG_W-1:0]        found_tag;
      logic [COUNT_NOW_W-1:0]  count_now;
   } res_type;

   function automatic logic signed [ID_W-1:0] rec_id(input logic [REC_W-1:0] rec);
      rec_id = $signed(rec[REC_W-1 -: ID_W]);
   endfunction

   function automatic logic [TAG_W-1:0] rec_tag(input logic [REC_W-1:0] rec);
      rec_tag = rec[TAG_W-1:0];
   endfunction

endpackage

>>> hw/rtl/sfst_ram.sv
module sfst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sfst_seq.sv
module sfst_seq
   import sfst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_take,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [ID_W-1:0]   req_record_id,
   input  logic [TAG_W-1:0]         req_record_tag,
   input  logic signed [ID_W-1:0]   req_search_key,
   input  logic                     res_take,
   input  logic [REC_W-1:0]         rd_data,
   output ram_ctl_type              ram_ctl,
   output seq_stat_type             stat,
   output res_type                  res
);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [ID_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]         i_ff, i_in;
   logic [CNT_W-1:0]         j_ff, j_in;
   logic                     pend_ff, pend_in;
   logic [CNT_W-1:0]         paddr_ff, paddr_in;
   logic [REC_W-1:0]         min_ff, min_in;
   logic [REC_W-1:0]         reci_ff, reci_in;
   logic [CNT_W-1:0]         m_ff, m_in;
   logic [FIB_W-1:0]         f_ff, f_in;
   logic [FIB_W-1:0]         f1_ff, f1_in;
   logic [FIB_W-1:0]         f2_ff, f2_in;
   logic signed [SW-1:0]     off_ff, off_in;
   logic [CNT_W-1:0]         p_ff, p_in;
   logic [REC_W-1:0]         hit_ff, hit_in;
   logic                     hit_flag_ff, hit_flag_in;
   logic [REC_W-1:0]         rec0_ff, rec0_in;
   status_type               status_ff, status_in;

   logic signed [SW-1:0]     probe_sum;
   logic signed [SW-1:0]     last_idx;
   logic signed [SW-1:0]     probe_cl;
   logic signed [SW-1:0]     off_next;
   logic                     last_ok;
   logic [CNT_W-1:0]         probe_idx;
   logic                     full;
   logic                     key_eq;

   // Fibonacci probe position, clamped to the held range.
   always_comb begin
      probe_sum = off_ff + $signed({1'b0, f2_ff});
      last_idx  = $signed({2'b00, count_ff}) - $signed(SW'(1));
      off_next  = off_ff + $signed(SW'(1));
      last_ok   = (f1_ff != '0) && (off_next < $signed({2'b00, count_ff}));
      probe_cl  = probe_sum;
      if (probe_sum > last_idx) begin
         probe_cl = last_idx;
      end
      if (probe_cl < $signed(SW'(0))) begin
         probe_cl = '0;
      end
      if (f_ff > FIB_W'(1)) begin
         probe_idx = probe_cl[CNT_W-1:0];
      end else begin
         probe_idx = off_next[CNT_W-1:0];
      end
   end

   assign full   = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign key_eq = (rec_id(rd_data) == key_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (op_type'(req_op) == OP_SEARCH) begin
                  if (count_ff == '0) begin
                     state_in = ST_DONE;
                  end else if (count_ff > CNT_W'(1)) begin
                     state_in = ST_SCAN;
                  end else begin
                     state_in = ST_FIB_INIT;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (j_ff == count_ff) begin
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            if ((CNT_W+1)'(i_ff) + (CNT_W+1)'(2) < (CNT_W+1)'(count_ff)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FIB_INIT;
            end
         end
         ST_FIB_INIT: begin
            if (f_ff >= FIB_W'(count_ff)) begin
               state_in = ST_FIB_RD;
            end
         end
         ST_FIB_RD: begin
            if (f_ff > FIB_W'(1)) begin
               state_in = ST_FIB_CMP;
            end else if (last_ok) begin
               state_in = ST_LAST_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FIB_CMP: begin
            if (key_eq) begin
               state_in = ST_HIT_RD;
            end else begin
               state_in = ST_FIB_RD;
            end
         end
         ST_LAST_CMP: begin
            if (key_eq) begin
               state_in = ST_HIT_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_HIT_RD: begin
            state_in = ST_HIT_W0;
         end
         ST_HIT_W0: begin
            state_in = ST_HIT_WH;
         end
         ST_HIT_WH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port and handshake outputs.
   always_comb begin
      ram_ctl.we    = 1'b0;
      ram_ctl.waddr = count_ff[ADDR_W-1:0];
      ram_ctl.wdata = {req_record_id, req_record_tag};
      ram_ctl.raddr = j_ff[ADDR_W-1:0];
      stat.idle     = 1'b0;
      stat.done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            stat.idle  = 1'b1;
            ram_ctl.we = req_take && (op_type'(req_op) == OP_LOAD) && !full;
         end
         ST_SWAP_A: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = i_ff[ADDR_W-1:0];
            ram_ctl.wdata = min_ff;
         end
         ST_SWAP_B: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = m_ff[ADDR_W-1:0];
            ram_ctl.wdata = reci_ff;
         end
         ST_FIB_RD: begin
            ram_ctl.raddr = probe_idx[ADDR_W-1:0];
         end
         ST_HIT_RD: begin
            ram_ctl.raddr = '0;
         end
         ST_HIT_W0: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = '0;
            ram_ctl.wdata = hit_ff;
         end
         ST_HIT_WH: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = p_ff[ADDR_W-1:0];
            ram_ctl.wdata = rec0_ff;
         end
         ST_DONE: begin
            stat.done = 1'b1;
         end
         default: begin
            stat.done = 1'b0;
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      count_in    = count_ff;
      key_in      = key_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pend_in     = pend_ff;
      paddr_in    = paddr_ff;
      min_in      = min_ff;
      reci_in     = reci_ff;
      m_in        = m_ff;
      f_in        = f_ff;
      f1_in       = f1_ff;
      f2_in       = f2_ff;
      off_in      = off_ff;
      p_in        = p_ff;
      hit_in      = hit_ff;
      hit_flag_in = hit_flag_ff;
      rec0_in     = rec0_ff;
      status_in   = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               key_in      = req_search_key;
               hit_flag_in = 1'b0;
               i_in        = '0;
               j_in        = '0;
               pend_in     = 1'b0;
               f_in        = FIB_W'(1);
               f1_in       = FIB_W'(1);
               f2_in       = '0;
               off_in      = '1;
               status_in   = STAT_OK;
               case (op_type'(req_op))
                  OP_LOAD: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        status_in = STAT_MISS;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Data read in the previous cycle is compared against the running minimum.
            if (pend_ff) begin
               if (paddr_ff == i_ff) begin
                  min_in  = rd_data;
                  reci_in = rd_data;
                  m_in    = i_ff;
               end else if (rec_id(rd_data) < rec_id(min_ff)) begin
                  min_in = rd_data;
                  m_in   = paddr_ff;
               end
            end
            if (j_ff < count_ff) begin
               pend_in  = 1'b1;
               paddr_in = j_ff;
               j_in     = j_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_SWAP_B: begin
            i_in    = i_ff + CNT_W'(1);
            j_in    = i_ff + CNT_W'(1);
            pend_in = 1'b0;
         end
         ST_FIB_INIT: begin
            if (f_ff < FIB_W'(count_ff)) begin
               f2_in = f1_ff;
               f1_in = f_ff;
               f_in  = f_ff + f1_ff;
            end
         end
         ST_FIB_RD: begin
            p_in = probe_idx;
         end
         ST_FIB_CMP: begin
            if (key_eq) begin
               hit_in      = rd_data;
               hit_flag_in = 1'b1;
               status_in   = STAT_OK;
            end else if (rec_id(rd_data) < key_ff) begin
               f_in   = f1_ff;
               f1_in  = f2_ff;
               f2_in  = f1_ff - f2_ff;
               off_in = $signed({2'b00, p_ff});
            end else begin
               f_in  = f2_ff;
               f1_in = f1_ff - f2_ff;
               f2_in = f2_ff - (f1_ff - f2_ff);
            end
         end
         ST_LAST_CMP: begin
            if (key_eq) begin
               hit_in      = rd_data;
               hit_flag_in = 1'b1;
               status_in   = STAT_OK;
            end
         end
         ST_HIT_W0: begin
            rec0_in = rd_data;
         end
         default: begin
            rec0_in = rec0_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         pend_ff     <= 1'b0;
         hit_flag_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_ff     <= pend_in;
         hit_flag_ff <= hit_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      paddr_ff  <= paddr_in;
      min_ff    <= min_in;
      reci_ff   <= reci_in;
      m_ff      <= m_in;
      f_ff      <= f_in;
      f1_ff     <= f1_in;
      f2_ff     <= f2_in;
      off_ff    <= off_in;
      p_ff      <= p_in;
      hit_ff    <= hit_in;
      rec0_ff   <= rec0_in;
      status_ff <= status_in;
   end

   always_comb begin
      res.status    = status_ff;
      res.found_id  = hit_flag_ff ? rec_id(hit_ff) : '0;
      res.found_tag = hit_flag_ff ? rec_tag(hit_ff) : '0;
      res.count_now = COUNT_NOW_W'(count_ff);
   end

endmodule

>>> hw/rtl/sorted_fibonacci_search_table_core.sv
// Sorted Fibonacci search table core.
// Requests arrive as req_ beats (op, record id, record tag, search key) and each
// request produces exactly one rsp_ beat (status, found id, found tag, count).
// A beat moves on a rising edge where valid is high and stall is low.
// A load appends a record, a clear empties the table, and a search first sorts
// the held records ascending by id with a selection sort, then runs a
// Fibonacci search for the key; a hit is swapped into slot 0 and returned.
// Records live in one synchronous RAM with a single read and a single write
// port, and its registered read sets the pace of the sort and the search.
// Load, clear and the unused opcode go straight to the done state. A search
// over n records sorts them, sizes the Fibonacci window, probes, and on a hit
// swaps the record into slot 0; a full table holds 128 records.
// One request is worked on at a time; req_stall is high while it is in flight.
// The response register frees the core as soon as a result is parked, so the
// next request is taken while a stalled response waits downstream.
// Synchronous reset empties the table and drops any pending response; the
// memory itself is not cleared, since only slots below the count are read.
module sorted_fibonacci_search_table_core
   import sfst_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OP_W-1:0]              req_op,
   input  logic signed [ID_W-1:0]       req_record_id,
   input  logic [TAG_W-1:0]             req_record_tag,
   input  logic signed [ID_W-1:0]       req_search_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic signed [ID_W-1:0]       rsp_found_id,
   output logic [TAG_W-1:0]             rsp_found_tag,
   output logic [COUNT_NOW_W-1:0]       rsp_count_now
);

   ram_ctl_type      ram_ctl;
   seq_stat_type     stat;
   res_type          res;
   logic [REC_W-1:0] rd_data;
   logic             req_take;
   logic             res_take;

   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff, rsp_in;

   // The core takes a request only from its idle state.
   assign req_stall = !stat.idle;
   assign req_take  = req_valid && !req_stall;

   // A finished result moves into the response register when that register
   // is empty or is being emptied in this cycle.
   assign res_take = stat.done && (!rsp_valid_ff || !rsp_stall);

   sfst_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.we),
      .wr_addr (ram_ctl.waddr),
      .wr_data (ram_ctl.wdata),
      .rd_addr (ram_ctl.raddr),
      .rd_data (rd_data)
   );

   sfst_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_take       (req_take),
      .req_op         (req_op),
      .req_record_id  (req_record_id),
      .req_record_tag (req_record_tag),
      .req_search_key (req_search_key),
      .res_take       (res_take),
      .rd_data        (rd_data),
      .ram_ctl        (ram_ctl),
      .stat           (stat),
      .res            (res)
   );

   always_comb begin
      rsp_in = rsp_ff;
      if (res_take) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_found_id  = rsp_ff.found_id;
   assign rsp_found_tag = rsp_ff.found_tag;
   assign rsp_count_now = rsp_ff.count_now;

   // A request in flight blocks the next one.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request accepted while previous request still in flight");

   // Only a hit carries record contents.
   a_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |->
         ((rsp_found_id == '0) && (rsp_found_tag == '0)))
      else $error("non-hit response carries record data");

   // A full report only comes from a full table.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_FULL)) |->
         (rsp_count_now == COUNT_NOW_W'(TABLE_DEPTH)))
      else $error("table full reported below capacity");

   // An empty report only comes from an empty table.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_EMPTY)) |-> (rsp_count_now == '0))
      else $error("table empty reported with records held");

endmodule
